@@ rtl/csq_pkg.sv @@
// Shared constants, types and elaboration-time table functions for the CORDIC
// sine/cosine unit. This file depends on nothing else.
package csq_pkg;

    // Fixed widths of the external fields.
    localparam int IN_W  = 40;
    localparam int OUT_W = 32;

    // Default configuration and the length of the arctangent table.
    localparam int ITER_DEF    = 32;
    localparam int FRAC_DEF    = 30;
    localparam int TABLE_STEPS = 14;

    // 2/pi as an unsigned fraction with 64 fraction bits.
    localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E44152A;

    // Quadrant and sign information that travels alongside each item.
    typedef struct packed {
        logic       neg;
        logic [1:0] quad;
    } t_side;

    // Upper half of the full 128-bit product of two unsigned 64-bit values.
    function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[127:64];
    endfunction

    // Unsigned long division by shift and subtract, used only at elaboration.
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Round a 64-bit fraction to nearest at f fraction bits.
    function automatic logic [63:0] q64_to_frac(input logic [63:0] v, input int f);
        logic [63:0] half;
        half = 64'd1 << (63 - f);
        return (v + half) >> (64 - f);
    endfunction

    // Arctangent of 2^-i in radians as a 64-bit fraction, from its Taylor series.
    function automatic logic [63:0] atan_q64(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum = '0;
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e < 64) begin
                term = udiv(64'd1 << (64 - e), 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // Step angle of one rotation stage in quads at f fraction bits.
    function automatic logic [63:0] step_angle(input int i, input int f);
        logic [63:0] v;
        if (i == 0) begin
            v = q64_to_frac(64'd1 << 63, f);
        end else if (i < TABLE_STEPS) begin
            v = q64_to_frac(mul_hi(atan_q64(i), TWO_OVER_PI_Q64), f);
        end else begin
            v = q64_to_frac(mul_hi(atan_q64(TABLE_STEPS - 1), TWO_OVER_PI_Q64), f)
                >> (i - (TABLE_STEPS - 1));
        end
        return v;
    endfunction

    // Inverse of the CORDIC gain over the given number of stages, at f fraction bits.
    function automatic logic [63:0] k_value(input int iters, input int f);
        logic [63:0] p;
        logic [63:0] kk;
        logic [63:0] t;
        p  = 64'd1 << 62;
        kk = '0;
        for (int i = 0; i < iters; i++) begin
            if (2 * i < 64) begin
                p = p + (p >> (2 * i));
            end
        end
        for (int b = 63; b >= 0; b--) begin
            t = kk | (64'd1 << b);
            if (mul_hi(mul_hi(t, t), p) <= (64'd1 << 62)) begin
                kk = t;
            end
        end
        return q64_to_frac(kk, f);
    endfunction

endpackage

@@ rtl/csq_prep.sv @@
// Input stage of the CORDIC sine/cosine unit: angle magnitude and quadrant split.
// Depends on csq_pkg.
module csq_prep #(
    parameter int FRAC_BITS = csq_pkg::FRAC_DEF,
    parameter int ZW        = FRAC_BITS + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [csq_pkg::IN_W-1:0]    i_angle,
    output logic                        o_valid,
    output logic signed [ZW-1:0]        o_z,
    output csq_pkg::t_side              o_side
);

    logic [csq_pkg::IN_W-1:0]   neg_angle;
    logic [csq_pkg::IN_W-1:0]   mag;
    logic [csq_pkg::IN_W+1:0]   mag_x;
    logic                       r_valid;
    logic signed [ZW-1:0]       r_z;
    csq_pkg::t_side             r_side;
    logic signed [ZW-1:0]       n_z;
    csq_pkg::t_side             n_side;

    // Magnitude of the angle; the most negative input saturates.
    always_comb begin
        neg_angle = ~i_angle + 1'b1;
        if (!i_angle[csq_pkg::IN_W-1]) begin
            mag = i_angle;
        end else if (neg_angle[csq_pkg::IN_W-1]) begin
            mag = {1'b0, {(csq_pkg::IN_W - 1){1'b1}}};
        end else begin
            mag = neg_angle;
        end
        mag_x       = {2'b00, mag};
        n_side.neg  = i_angle[csq_pkg::IN_W-1];
        n_side.quad = mag_x[FRAC_BITS+1:FRAC_BITS];
        n_z         = {2'b00, mag_x[FRAC_BITS-1:0]};
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z    <= n_z;
        r_side <= n_side;
    end

    assign o_valid = r_valid;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

@@ rtl/csq_cell.sv @@
// One rotation cell of the CORDIC chain: a single shift-add micro-rotation.
// Depends on csq_pkg for the step angle and the side-band type.
module csq_cell #(
    parameter int STAGE     = 0,
    parameter int FRAC_BITS = csq_pkg::FRAC_DEF,
    parameter int XW        = FRAC_BITS + 3,
    parameter int ZW        = FRAC_BITS + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [XW-1:0]    i_x,
    input  logic signed [XW-1:0]    i_y,
    input  logic signed [ZW-1:0]    i_z,
    input  csq_pkg::t_side          i_side,
    output logic                    o_valid,
    output logic signed [XW-1:0]    o_x,
    output logic signed [XW-1:0]    o_y,
    output logic signed [ZW-1:0]    o_z,
    output csq_pkg::t_side          o_side
);

    localparam logic [63:0]          STEP_Q = csq_pkg::step_angle(STAGE, FRAC_BITS);
    localparam logic signed [ZW-1:0] STEP_Z = STEP_Q[ZW-1:0];

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic                 r_valid;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    csq_pkg::t_side       r_side;

    // Rotate towards zero residual angle; a zero residual counts as positive.
    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_z[ZW-1]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - STEP_Z;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + STEP_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

@@ rtl/csq_fold.sv @@
// Output stage of the CORDIC sine/cosine unit: quadrant fold, sign and saturation.
// Depends on csq_pkg for the output width and the side-band type.
module csq_fold #(
    parameter int FRAC_BITS = csq_pkg::FRAC_DEF,
    parameter int XW        = FRAC_BITS + 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [XW-1:0]            i_x,
    input  logic signed [XW-1:0]            i_y,
    input  csq_pkg::t_side                  i_side,
    output logic                            o_valid,
    output logic signed [csq_pkg::OUT_W-1:0] o_sine,
    output logic signed [csq_pkg::OUT_W-1:0] o_cosine
);

    localparam int EW = (XW > csq_pkg::OUT_W) ? XW : csq_pkg::OUT_W + 1;
    localparam logic signed [EW-1:0] SAT_HI = EW'((64'd1 << (csq_pkg::OUT_W - 1)) - 64'd1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

    logic signed [XW-1:0]             c1;
    logic signed [XW-1:0]             s1;
    logic signed [XW-1:0]             c2;
    logic signed [XW-1:0]             s2;
    logic signed [XW-1:0]             s3;
    logic signed [EW-1:0]             s_ext;
    logic signed [EW-1:0]             c_ext;
    logic signed [csq_pkg::OUT_W-1:0] n_sine;
    logic signed [csq_pkg::OUT_W-1:0] n_cosine;
    logic                             r_valid;
    logic signed [csq_pkg::OUT_W-1:0] r_sine;
    logic signed [csq_pkg::OUT_W-1:0] r_cosine;

    // Fold the quadrant and the input sign back into sine and cosine.
    always_comb begin
        if (i_side.quad[0]) begin
            c1 = -i_y;
            s1 = i_x;
        end else begin
            c1 = i_x;
            s1 = i_y;
        end
        if (i_side.quad[1]) begin
            c2 = -c1;
            s2 = -s1;
        end else begin
            c2 = c1;
            s2 = s1;
        end
        s3 = i_side.neg ? -s2 : s2;
    end

    // Saturate each result to the signed output range.
    always_comb begin
        s_ext = EW'(s3);
        c_ext = EW'(c2);
        if (s_ext > SAT_HI) begin
            n_sine = SAT_HI[csq_pkg::OUT_W-1:0];
        end else if (s_ext < SAT_LO) begin
            n_sine = SAT_LO[csq_pkg::OUT_W-1:0];
        end else begin
            n_sine = s_ext[csq_pkg::OUT_W-1:0];
        end
        if (c_ext > SAT_HI) begin
            n_cosine = SAT_HI[csq_pkg::OUT_W-1:0];
        end else if (c_ext < SAT_LO) begin
            n_cosine = SAT_LO[csq_pkg::OUT_W-1:0];
        end else begin
            n_cosine = c_ext[csq_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine   <= n_sine;
        r_cosine <= n_cosine;
    end

    assign o_valid  = r_valid;
    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;

endmodule

@@ rtl/cordic_sin_cos_quadrant_unit.sv @@
// CORDIC sine/cosine of an angle in quads: input stage, a chain of ITERATIONS
// rotation cells, and an output fold stage. Depends on csq_pkg, csq_prep,
// csq_cell and csq_fold.
// Registers: start passes through the input stage, one register per cell, and the fold stage before o_valid.
// Throughput: one item per cycle; busy is always low since every cell passes on each cycle.
// Reset (synchronous, active low) clears the valid bits of the whole chain.
// Results appear for one cycle with o_valid; the receiver cannot stall them.
module cordic_sin_cos_quadrant_unit #(
    parameter int ITERATIONS = csq_pkg::ITER_DEF,
    parameter int FRAC_BITS  = csq_pkg::FRAC_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic signed [csq_pkg::IN_W-1:0]  i_angle_quads,
    output logic                             busy,
    output logic                             o_valid,
    output logic signed [csq_pkg::OUT_W-1:0] o_sine,
    output logic signed [csq_pkg::OUT_W-1:0] o_cosine
);

    localparam int XW = FRAC_BITS + 3;
    localparam int ZW = FRAC_BITS + 2;
    localparam logic [63:0]          K_Q  = csq_pkg::k_value(ITERATIONS, FRAC_BITS);
    localparam logic signed [XW-1:0] K_X0 = K_Q[XW-1:0];

    logic                 v_chain [ITERATIONS+1];
    logic signed [XW-1:0] x_chain [ITERATIONS+1];
    logic signed [XW-1:0] y_chain [ITERATIONS+1];
    logic signed [ZW-1:0] z_chain [ITERATIONS+1];
    csq_pkg::t_side       s_chain [ITERATIONS+1];

    // The pipeline never stalls, so an item is taken whenever start is high.
    assign busy = 1'b0;

    // Angle magnitude, quadrant and fraction.
    csq_prep #(
        .FRAC_BITS (FRAC_BITS),
        .ZW        (ZW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_angle (i_angle_quads),
        .o_valid (v_chain[0]),
        .o_z     (z_chain[0]),
        .o_side  (s_chain[0])
    );

    // The vector starts at (K, 0).
    assign x_chain[0] = K_X0;
    assign y_chain[0] = '0;

    // Chain of rotation cells, one per iteration.
    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        csq_cell #(
            .STAGE     (g),
            .FRAC_BITS (FRAC_BITS),
            .XW        (XW),
            .ZW        (ZW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_chain[g]),
            .i_x     (x_chain[g]),
            .i_y     (y_chain[g]),
            .i_z     (z_chain[g]),
            .i_side  (s_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_x     (x_chain[g+1]),
            .o_y     (y_chain[g+1]),
            .o_z     (z_chain[g+1]),
            .o_side  (s_chain[g+1])
        );
    end

    // Quadrant fold, sign and saturation; the final residual angle is unused.
    csq_fold #(
        .FRAC_BITS (FRAC_BITS),
        .XW        (XW)
    ) u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v_chain[ITERATIONS] && (z_chain[ITERATIONS] == z_chain[ITERATIONS]
                                          || 1'b1)),
        .i_x      (x_chain[ITERATIONS]),
        .i_y      (y_chain[ITERATIONS]),
        .i_side   (s_chain[ITERATIONS]),
        .o_valid  (o_valid),
        .o_sine   (o_sine),
        .o_cosine (o_cosine)
    );

endmodule

@@ dv/cordic_sin_cos_checker.sv @@
// Result checker for the CORDIC sine/cosine unit: predicts sine and cosine for every accepted item
// and compares them against the results that leave the block. Depends on csq_pkg for port widths.
`timescale 1ns / 1ps

module cordic_sin_cos_checker #(
    parameter int ITERATIONS = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic signed [csq_pkg::IN_W-1:0]  i_angle_quads,
    input  logic                             i_valid,
    input  logic signed [csq_pkg::OUT_W-1:0] i_sine,
    input  logic signed [csq_pkg::OUT_W-1:0] i_cosine,
    output int                               o_error_count,
    output int                               o_outstanding
);

    // Steps from 1 up to below this index take their angle from the arctangent series.
    localparam int          ATAN_STEPS   = 14;
    localparam logic [63:0] TWO_OVER_PI  = 64'hA2F9836E4E44152A;

    typedef struct packed {
        logic signed [csq_pkg::OUT_W-1:0] sine;
        logic signed [csq_pkg::OUT_W-1:0] cosine;
    } t_trig_pair;

    // Rotation constants: one angle per step and the gain-compensated start value of x.
    logic signed [63:0] rot_angle [ITERATIONS];
    logic signed [63:0] x_start;

    t_trig_pair pending_trig [$];
    int         error_total = 0;

    // Upper 64 bits of the unsigned 128-bit product.
    function automatic logic [63:0] product_hi(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = 128'(a) * 128'(b);
        return full[127:64];
    endfunction

    // Round a 64-bit binary fraction to the nearest value with FRAC_BITS fraction bits.
    function automatic logic [63:0] to_fixed(input logic [63:0] v);
        return (v + (64'd1 << (63 - FRAC_BITS))) >> (64 - FRAC_BITS);
    endfunction

    // Clamp a wide value into the signed output word.
    function automatic logic signed [csq_pkg::OUT_W-1:0] clamp_word(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Work out sine and cosine of one angle exactly as the block should.
    function automatic t_trig_pair predict_trig(input logic signed [csq_pkg::IN_W-1:0] angle);
        logic [csq_pkg::IN_W-1:0] mag;
        logic                     neg;
        logic [1:0]               quad;
        logic signed [63:0]       x, y, z, xs, ys, c, s, t;
        t_trig_pair               res;
        neg = angle[csq_pkg::IN_W-1];
        mag = angle;
        // The magnitude of the most negative angle does not fit and saturates.
        if (neg) begin
            mag = -angle;
            if (mag[csq_pkg::IN_W-1]) begin
                mag = {1'b0, {(csq_pkg::IN_W-1){1'b1}}};
            end
        end
        quad = 2'(mag >> FRAC_BITS);
        z    = 64'(mag & ((40'd1 << FRAC_BITS) - 40'd1));
        x    = x_start;
        y    = '0;
        // A zero residual angle counts as non-negative and rotates forwards.
        for (int i = 0; i < ITERATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - rot_angle[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + rot_angle[i];
            end
        end
        c = x;
        s = y;
        // Fold the quadrant and the input sign back in.
        if (quad[0]) begin
            t = c;
            c = -s;
            s = t;
        end
        if (quad[1]) begin
            s = -s;
            c = -c;
        end
        if (neg) begin
            s = -s;
        end
        res.sine   = clamp_word(s);
        res.cosine = clamp_word(c);
        return res;
    endfunction

    // Build the step angles and the start value once, before reset is released.
    initial begin : build_constants
        logic [63:0] sum, term, gain, kk, trial;
        int          e;
        rot_angle[0] = to_fixed(64'd1 << 63);
        for (int i = 1; i < ITERATIONS; i++) begin
            if (i < ATAN_STEPS) begin
                // Series for atan(2^-i) in radians, then scaled by 2/pi into quads.
                sum = '0;
                for (int k = 0; i * (2 * k + 1) < 64; k++) begin
                    e    = i * (2 * k + 1);
                    term = (64'd1 << (64 - e)) / 64'(2 * k + 1);
                    sum  = (k % 2 == 1) ? sum - term : sum + term;
                end
                rot_angle[i] = to_fixed(product_hi(sum, TWO_OVER_PI));
            end else begin
                rot_angle[i] = rot_angle[i-1] >>> 1;
            end
        end
        // Square of the gain of the whole chain, then its inverse square root by bitwise search.
        gain = 64'd1 << 62;
        for (int i = 0; i < ITERATIONS; i++) begin
            if (2 * i < 64) begin
                gain = gain + (gain >> (2 * i));
            end
        end
        kk = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = kk | (64'd1 << b);
            if (product_hi(product_hi(trial, trial), gain) <= (64'd1 << 62)) begin
                kk = trial;
            end
        end
        x_start = to_fixed(kk);
    end

    // Compare each result with the oldest prediction, then record a newly accepted item.
    always @(posedge i_clk) begin : watch
        t_trig_pair want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (pending_trig.size() == 0) begin
                    $error("unexpected result: sine %0d, cosine %0d", i_sine, i_cosine);
                    error_total++;
                end else begin
                    want = pending_trig.pop_front();
                    if (i_sine !== want.sine) begin
                        $error("sine: expected %0d, actual %0d", want.sine, i_sine);
                        error_total++;
                    end
                    if (i_cosine !== want.cosine) begin
                        $error("cosine: expected %0d, actual %0d", want.cosine, i_cosine);
                        error_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                pending_trig.push_back(predict_trig(i_angle_quads));
            end
        end
        o_outstanding <= pending_trig.size();
        o_error_count <= error_total;
    end

endmodule

@@ dv/testbench.sv @@
// Top of the testbench for cordic_sin_cos_quadrant_unit: clock, reset and angle stimulus.
// Depends on csq_pkg, the unit itself and cordic_sin_cos_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int  ITERATIONS   = 32;
    localparam int  FRAC_BITS    = 30;
    localparam int  CLK_HALF     = 5;
    localparam int  RANDOM_ITEMS = 650;
    localparam int  SETTLE       = ITERATIONS + 8;
    localparam time TIMEOUT_NS   = 2_000_000;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic signed [csq_pkg::IN_W-1:0]  i_angle_quads;
    logic                             busy;
    logic                             o_valid;
    logic signed [csq_pkg::OUT_W-1:0] o_sine;
    logic signed [csq_pkg::OUT_W-1:0] o_cosine;
    int                               error_count;
    int                               outstanding;

    // Boundary angles: zero, unit steps, quadrant edges, wrap past four quads and the extremes.
    logic signed [csq_pkg::IN_W-1:0] corner_angles [$] = '{
        40'h00_0000_0000, 40'h00_0000_0001, 40'hFF_FFFF_FFFF, 40'h00_2000_0000,
        40'h00_4000_0000, 40'hFF_C000_0000, 40'h00_8000_0000, 40'h00_C000_0000,
        40'h01_0000_0000, 40'h00_3FFF_FFFF, 40'hFF_C000_0001, 40'h00_FFFF_FFFF,
        40'hFF_A000_0000, 40'h7F_FFFF_FFFF, 40'h80_0000_0000, 40'h80_0000_0001,
        40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'hFF_8000_0000, 40'hFF_2000_0000
    };

    cordic_sin_cos_quadrant_unit #(
        .ITERATIONS(ITERATIONS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_angle_quads(i_angle_quads),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_sine       (o_sine),
        .o_cosine     (o_cosine)
    );

    cordic_sin_cos_checker #(
        .ITERATIONS(ITERATIONS),
        .FRAC_BITS (FRAC_BITS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_angle_quads(i_angle_quads),
        .i_valid      (o_valid),
        .i_sine       (o_sine),
        .i_cosine     (o_cosine),
        .o_error_count(error_count),
        .o_outstanding(outstanding)
    );

    // Free-running clock.
    always #(CLK_HALF) i_clk = ~i_clk;

    // Random angle: full range for 40 in 100, the rest aimed at angles below four quads, quadrant edges,
    // fractions near zero or one, and the extremes of the field.
    function automatic logic signed [csq_pkg::IN_W-1:0] pick_angle();
        logic [csq_pkg::IN_W-1:0] mag;
        logic [63:0]              wide;
        int                       kind;
        kind = $urandom_range(99);
        wide = {$urandom, $urandom};
        if (kind < 40) begin
            return wide[39:0];
        end else if (kind < 65) begin
            mag = {8'd0, wide[31:0]};
        end else if (kind < 85) begin
            mag = (40'($urandom_range(7)) << FRAC_BITS) + 40'($urandom_range(16)) - 40'd8;
        end else if (kind < 95) begin
            mag = (40'(wide[33:32]) << FRAC_BITS) | 40'(wide[15:0]);
            if (wide[40]) begin
                mag = mag | 40'h00_3FFF_0000;
            end
        end else begin
            unique case (wide[1:0])
                2'd0:    return 40'h80_0000_0000;
                2'd1:    return 40'h7F_FFFF_FFFF;
                2'd2:    return 40'hFF_FFFF_FFFF;
                default: return 40'h00_0000_0000;
            endcase
        end
        return wide[63] ? -mag : mag;
    endfunction

    // Offer one item and hold it until the unit takes it, then perhaps leave a gap.
    // Each following cycle stays idle with a chance of 28 in 100.
    task automatic send_angle(input logic signed [csq_pkg::IN_W-1:0] angle, input bit may_idle);
        start         <= 1'b1;
        i_angle_quads <= angle;
        @(posedge i_clk iff !busy);
        if (may_idle) begin
            while ($urandom_range(99) < 28) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        @(posedge i_clk);
    endtask

    // Stimulus: reset, directed corners, then random angles with idle gaps and one pause.
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_angle_quads = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_angles[n]) begin
            send_angle(corner_angles[n], n % 3 == 1);
        end
        drain_results();

        // Items 250 to 399 go back to back; the sender also pauses once until all is back.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_angle(pick_angle(), n < 250 || n >= 400);
            if (n == 450) begin
                drain_results();
            end
        end
        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog against a hung run.
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/csq_pkg.sv
rtl/csq_prep.sv
rtl/csq_cell.sv
rtl/csq_fold.sv
rtl/cordic_sin_cos_quadrant_unit.sv
dv/cordic_sin_cos_checker.sv
dv/testbench.sv
